@@ sv/aes_ctr_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_ctr_pkg
// AES-128 round helpers and field widths for the counter-mode PES decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_ctr_pkg;

    localparam int BLK_W   = 128;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W   = 5;
    localparam int NROUNDS = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KS_HI  = 3'd0,
        REG_KS_LO  = 3'd1,
        REG_LC_HI  = 3'd2,
        REG_LC_LO  = 3'd3,
        REG_RIV    = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_DATA  = 1'b1
    } t_action;

    // first entry in the top byte
    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] v);
        return SBOX_TBL[2047 - 8*int'(v) -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        case (r)
            4'd1:    c = 8'h01;
            4'd2:    c = 8'h02;
            4'd3:    c = 8'h04;
            4'd4:    c = 8'h08;
            4'd5:    c = 8'h10;
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h40;
            4'd8:    c = 8'h80;
            4'd9:    c = 8'h1b;
            4'd10:   c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] rk,
                                                  input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, tmp;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        tmp = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tmp;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] st,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic fin);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [BLK_W-1:0] res;
        for (int i = 0; i < 16; i++) begin
            b[i] = st[127-8*i -: 8];
        end
        // sub bytes and shift rows: row j of column c from column c+j
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[4*c+j] = sbox(b[4*((c+j)%4)+j]);
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127-8*i -: 8] = t[i];
        end
        return res ^ rk;
    endfunction

endpackage

`default_nettype wire

@@ sv/aes128_ctr_pes_decryptor.sv @@
// ----------------------------------------------------------------------------
// aes128_ctr_pes_decryptor
// AES-128 counter-mode decryption of PES payload blocks, one round per stage.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | content
//  s_axis   | in        | i_s_axis_tvalid/o_..._tready | start or data item
//  m_axis   | out       | o_m_axis_tvalid/i_..._tready | decrypted block
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | key, lc and riv writes
//
//  Path from input accept to result: input register with the
//  initial key add, nine round stages, then the final round plus keystream
//  XOR into the result register.
//  One item per cycle; the whole pipe advances when the result register is
//  empty or being taken, so a downstream stall backs up to i_s_axis.
//  Start items and zero-length blocks give no result. Synchronous reset
//  clears counters, config registers, stage valid bits and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_ctr_pes_decryptor (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // stream_counter[31:0] input_counter[95:32] data_hi[159:96]
    // data_lo[223:160] byte_count[228:224] zero[231:229]
    input  wire logic [231:0] i_s_axis_tdata,
    // action
    input  wire logic         i_s_axis_tuser,
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // plain_hi[63:0] plain_lo[127:64] valid_bytes[132:128] zero[135:133]
    output logic [135:0]      o_m_axis_tdata,
    output logic              o_m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [aes_ctr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);

    // stage 0 holds the initial key add, stages 1..9 the full rounds
    localparam int NST = aes_ctr_pkg::NROUNDS;

    logic [63:0] r_ks_hi, r_ks_lo, r_lc_hi, r_lc_lo, r_riv;
    logic [63:0] r_iv_upper, r_block_ctr;

    logic [aes_ctr_pkg::BLK_W-1:0] r_st  [NST];
    logic [aes_ctr_pkg::BLK_W-1:0] r_rk  [NST];
    logic [aes_ctr_pkg::BLK_W-1:0] r_dat [NST];
    logic [aes_ctr_pkg::CNT_W-1:0] r_n   [NST];
    logic [NST-1:0]                r_lst;
    logic [NST-1:0]                r_vld;

    logic [aes_ctr_pkg::BLK_W-1:0] r_plain;
    logic [aes_ctr_pkg::CNT_W-1:0] r_out_n;
    logic                          r_out_last;
    logic                          r_out_vld;

    logic        adv, in_acc, is_data, blk_go;
    logic [31:0] in_sc;
    logic [63:0] in_ic, in_dhi, in_dlo;
    logic [aes_ctr_pkg::CNT_W-1:0] in_bc, in_n;
    logic [aes_ctr_pkg::BLK_W-1:0] key0, ctr_blk, rk10, ks, plain_full, mask;

    assign in_sc  = i_s_axis_tdata[31:0];
    assign in_ic  = i_s_axis_tdata[95:32];
    assign in_dhi = i_s_axis_tdata[159:96];
    assign in_dlo = i_s_axis_tdata[223:160];
    assign in_bc  = i_s_axis_tdata[228:224];

    assign adv     = !r_out_vld || i_m_axis_tready;
    assign in_acc  = i_s_axis_tvalid && adv;
    assign is_data = (i_s_axis_tuser == aes_ctr_pkg::ACT_DATA);
    assign blk_go  = in_acc && is_data && (in_bc != '0);
    assign in_n    = (in_bc > 5'd16) ? 5'd16 : in_bc;
    assign key0    = {r_ks_hi ^ r_lc_hi, r_ks_lo ^ r_lc_lo};
    assign ctr_blk = {r_iv_upper, r_block_ctr};

    // last round and keystream
    assign rk10 = aes_ctr_pkg::key_next(r_rk[NST-1], 4'(aes_ctr_pkg::NROUNDS));
    assign ks   = aes_ctr_pkg::aes_round(r_st[NST-1], rk10, 1'b1);
    assign plain_full = r_dat[NST-1] ^ ks;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            mask[127-8*i -: 8] = (5'(i) < r_n[NST-1]) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks_hi     <= '0;
            r_ks_lo     <= '0;
            r_lc_hi     <= '0;
            r_lc_lo     <= '0;
            r_riv       <= '0;
            r_iv_upper  <= '0;
            r_block_ctr <= '0;
            r_vld       <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    aes_ctr_pkg::REG_KS_HI: r_ks_hi <= i_cfg_data;
                    aes_ctr_pkg::REG_KS_LO: r_ks_lo <= i_cfg_data;
                    aes_ctr_pkg::REG_LC_HI: r_lc_hi <= i_cfg_data;
                    aes_ctr_pkg::REG_LC_LO: r_lc_lo <= i_cfg_data;
                    aes_ctr_pkg::REG_RIV:   r_riv   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && !is_data) begin
                r_iv_upper  <= r_riv ^ {32'd0, in_sc};
                r_block_ctr <= in_ic;
            end else if (blk_go) begin
                r_block_ctr <= r_block_ctr + 64'd1;
            end
            if (adv) begin
                r_vld     <= {r_vld[NST-2:0], blk_go};
                r_out_vld <= r_vld[NST-1];
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0]  <= ctr_blk ^ key0;
            r_rk[0]  <= key0;
            r_dat[0] <= {in_dhi, in_dlo};
            r_n[0]   <= in_n;
            r_lst[0] <= i_s_axis_tlast;
            for (int k = 1; k < NST; k++) begin
                r_rk[k]  <= aes_ctr_pkg::key_next(r_rk[k-1], 4'(k));
                r_st[k]  <= aes_ctr_pkg::aes_round(r_st[k-1],
                                aes_ctr_pkg::key_next(r_rk[k-1], 4'(k)), 1'b0);
                r_dat[k] <= r_dat[k-1];
                r_n[k]   <= r_n[k-1];
                r_lst[k] <= r_lst[k-1];
            end
            r_plain    <= plain_full & mask;
            r_out_n    <= r_n[NST-1];
            r_out_last <= r_lst[NST-1];
        end
    end

    assign o_s_axis_tready = adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'd0, r_out_n, r_plain[63:0], r_plain[127:64]};

`ifndef SYNTHESIS
    a_start_loads_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_data) |=> (r_block_ctr == $past(in_ic)))
        else $error("start item did not load the block counter");

    a_blk_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_go |=> (r_block_ctr == $past(r_block_ctr) + 64'd1) && r_vld[0])
        else $error("data block did not advance counter or enter pipe");

    a_empty_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_data && in_bc == '0) |=> !r_vld[0])
        else $error("zero-length block entered the pipe");

    a_out_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_n != '0) && (r_out_n <= 5'd16))
        else $error("result length out of range");
`endif

endmodule

`default_nettype wire

@@ sim/tb_aes128_ctr_pes_decryptor.sv @@
// ----------------------------------------------------------------------------
// tb_aes128_ctr_pes_decryptor
// Self-checking bench: directed rows then random PES payloads, with every
// decrypted block checked against a behavioral AES-128 counter-mode model or a typed-in result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_aes128_ctr_pes_decryptor;

    typedef struct {
        aes_ctr_pkg::t_action act;
        logic [31:0] strm_cnt;
        logic [63:0] in_cnt;
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [4:0]  nbytes;
        logic        last;
    } t_blk_in;

    typedef struct {
        logic [63:0] phi;
        logic [63:0] plo;
        logic [4:0]  nvalid;
        logic        eop;
    } t_plain;

    typedef struct {
        t_blk_in item;
        logic    has_exp;   // expected result typed in directly
        t_plain  exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic [231:0] i_s_axis_tdata = '0;
    logic i_s_axis_tuser = 1'b0;
    logic i_s_axis_tlast = 1'b0;
    logic i_m_axis_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [aes_ctr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    wire o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tlast, o_cfg_ready;
    wire [135:0] o_m_axis_tdata;

    aes128_ctr_pes_decryptor u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb_aes128_ctr_pes_decryptor: FAIL");
        $finish;
    end

    // predictor state
    logic [63:0] m_ks_hi, m_ks_lo, m_lc_hi, m_lc_lo, m_riv, m_iv_up, m_ctr;
    t_plain plain_q[$];
    int n_err = 0, n_res = 0, n_items = 0;
    int stall_mode = 0;   // 0 random, 1 never stall, 2 long hold-off
    bit no_idle = 0;

    logic [7:0] sb [256];
    initial for (int i = 0; i < 256; i++) sb[i] = aes_ctr_pkg::SBOX_TBL[2047-8*i -: 8];

    function automatic logic [7:0] mul2(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] pt);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w0, w1, w2, w3, x, rc, a0, a1, a2, a3, al;
        logic [127:0] r;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            s[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
            if (i % 16 == 0) begin
                x = w0;
                w0 = sb[w1] ^ rc; w1 = sb[w2]; w2 = sb[w3]; w3 = sb[x];
                rc = mul2(rc);
            end
            rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
            rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    t[4*c+j] = sb[s[4*((c+j)%4)+j]];
            if (rnd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    // returns 1 and fills res when the item yields a decrypted block
    function automatic bit decrypt_block(t_blk_in it, output t_plain res);
        logic [127:0] ks, d;
        int n;
        res = '{default: '0};
        if (it.act == aes_ctr_pkg::ACT_START) begin
            m_iv_up = m_riv ^ {32'h0, it.strm_cnt};
            m_ctr = it.in_cnt;
            return 0;
        end
        n = it.nbytes;
        if (n == 0) return 0;
        if (n > 16) n = 16;
        ks = aes_encrypt({m_ks_hi ^ m_lc_hi, m_ks_lo ^ m_lc_lo}, {m_iv_up, m_ctr});
        d = {it.dhi, it.dlo} ^ ks;
        for (int i = n; i < 16; i++) d[127-8*i -: 8] = 8'h00;
        m_ctr = m_ctr + 64'd1;
        res.phi = d[127:64];
        res.plo = d[63:0];
        res.nvalid = 5'(n);
        res.eop = it.last;
        return 1;
    endfunction

    task automatic wait_drained();
        while (plain_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(aes_ctr_pkg::t_cfg_reg idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            aes_ctr_pkg::REG_KS_HI: m_ks_hi = val;
            aes_ctr_pkg::REG_KS_LO: m_ks_lo = val;
            aes_ctr_pkg::REG_LC_HI: m_lc_hi = val;
            aes_ctr_pkg::REG_LC_LO: m_lc_lo = val;
            default:                m_riv = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_keys(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d, logic [63:0] e);
        write_reg(aes_ctr_pkg::REG_KS_HI, a);
        write_reg(aes_ctr_pkg::REG_KS_LO, b);
        write_reg(aes_ctr_pkg::REG_LC_HI, c);
        write_reg(aes_ctr_pkg::REG_LC_LO, d);
        write_reg(aes_ctr_pkg::REG_RIV, e);
    endtask

    // offers one item from a falling edge and returns at the falling edge after accept
    task automatic send_item(t_blk_in it, bit has_exp, t_plain exp_in);
        t_plain pr;
        while (!no_idle && $urandom_range(99) < 11) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = it.act;
        i_s_axis_tlast = it.last;
        i_s_axis_tdata = {3'b000, it.nbytes, it.dlo, it.dhi, it.in_cnt, it.strm_cnt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (decrypt_block(it, pr)) plain_q.push_back(has_exp ? exp_in : pr);
        n_items++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_mode == 2) begin
                i_m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                stall_mode = 0;
            end
            i_m_axis_tready = (stall_mode == 1) || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        t_plain e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (plain_q.size() == 0) begin
                $error("unexpected result %h", o_m_axis_tdata);
                n_err++;
            end else begin
                e = plain_q.pop_front();
                n_res++;
                if (o_m_axis_tdata[63:0] !== e.phi) begin
                    $error("plain_hi exp %h got %h", e.phi, o_m_axis_tdata[63:0]);
                    n_err++;
                end
                if (o_m_axis_tdata[127:64] !== e.plo) begin
                    $error("plain_lo exp %h got %h", e.plo, o_m_axis_tdata[127:64]);
                    n_err++;
                end
                if (o_m_axis_tdata[132:128] !== e.nvalid) begin
                    $error("valid_bytes exp %0d got %0d", e.nvalid,
                           o_m_axis_tdata[132:128]);
                    n_err++;
                end
                if (o_m_axis_tdata[135:133] !== 3'b000) begin
                    $error("pad exp 0 got %0d", o_m_axis_tdata[135:133]);
                    n_err++;
                end
                if (o_m_axis_tlast !== e.eop) begin
                    $error("end_of_payload exp %0b got %0b", e.eop, o_m_axis_tlast);
                    n_err++;
                end
            end
        end
    end

    function automatic t_blk_in mk(aes_ctr_pkg::t_action a, logic [31:0] sc,
                                   logic [63:0] ic, logic [63:0] h, logic [63:0] l,
                                   logic [4:0] n, logic t);
        t_blk_in r;
        r.act = a; r.strm_cnt = sc; r.in_cnt = ic; r.dhi = h; r.dlo = l;
        r.nbytes = n; r.last = t;
        return r;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    initial begin
        t_row rows[$];
        t_blk_in it;
        t_plain none;
        int nblk;
        none = '{default: '0};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        m_ks_hi = 0; m_ks_lo = 0; m_lc_hi = 0; m_lc_lo = 0; m_riv = 0;
        m_iv_up = 0; m_ctr = 0;

        // data before any start uses the all-zero counter block and key
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, 0, 0, 5'd16, 1'b0), 1'b1,
                         '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 5'd16, 1'b0}});
        // zero-length block: nothing out, counter held
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, ONES, 5'd0, 1'b1),
                         1'b0, none});
        // count above sixteen saturates
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, ONES, 5'd31, 1'b1),
                         1'b0, none});
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, 0, 5'd17, 1'b0),
                         1'b0, none});
        // counter wraps at 64 bits
        rows.push_back('{mk(aes_ctr_pkg::ACT_START, ONES[31:0], ONES - 1, 0, 0,
                            5'd0, 1'b0), 1'b0, none});
        for (int i = 0; i < 4; i++)
            rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, ONES, 5'(1 + i * 5),
                                i[0]), 1'b0, none});
        rows.push_back('{mk(aes_ctr_pkg::ACT_START, 0, 0, ONES, ONES, 5'd31, 1'b1),
                         1'b0, none});
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, ONES[31:0], ONES, 0, ONES, 5'd1, 1'b1),
                         1'b0, none});
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, ONES, 5'd8, 1'b0),
                         1'b0, none});
        rows.push_back('{mk(aes_ctr_pkg::ACT_DATA, 0, 0, ONES, ONES, 5'd9, 1'b1),
                         1'b0, none});
        foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
        wait_drained();

        // several key settings, extremes included
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_keys(ONES, ONES, 0, 0, ONES);
                1: load_keys(ONES, 0, ONES, 0, 0);
                2: load_keys(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 0, 0, rnd64());
                default: load_keys(rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
            endcase
            if (phase == 1) stall_mode = 1;
            if (phase == 3) no_idle = 1;
            if (phase == 4) begin
                no_idle = 0;
                stall_mode = 2;   // long hold-off while items keep coming
            end else if (phase != 1) stall_mode = (phase == 3) ? 1 : 0;
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(9) == 0) begin
                    // noise: random action and fields
                    it = mk(aes_ctr_pkg::t_action'($urandom_range(1)), $urandom, rnd64(),
                            rnd64(), rnd64(), 5'($urandom), 1'($urandom_range(1)));
                    send_item(it, 1'b0, none);
                end else begin
                    it = mk(aes_ctr_pkg::ACT_START, $urandom,
                            ($urandom_range(3) == 0) ? ONES - 2 : rnd64(),
                            rnd64(), rnd64(), 5'($urandom), 1'($urandom_range(1)));
                    send_item(it, 1'b0, none);
                    nblk = $urandom_range(1, 6);
                    for (int b = 0; b < nblk; b++) begin
                        it = mk(aes_ctr_pkg::ACT_DATA, $urandom, rnd64(), rnd64(), rnd64(),
                                (b == nblk - 1) ? 5'($urandom_range(1, 16)) : 5'd16,
                                b == nblk - 1);
                        send_item(it, 1'b0, none);
                        k++;
                    end
                end
            end
            // sender pauses until every result is back
            wait_drained();
        end

        $display("covered %0d items, %0d decrypted blocks, 6 key settings, long stall",
                 n_items, n_res);
        if (n_err == 0 && plain_q.size() == 0) begin
            $display("tb_aes128_ctr_pes_decryptor: PASS");
        end else begin
            $display("tb_aes128_ctr_pes_decryptor: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
